// ===== src/ppm_pkg.sv =====
// Shared types, constants and helper functions of the PPM decoder.
`default_nettype none

package ppm_pkg;

  // Register reset values
  localparam logic [15:0] SYNC_MIN_RST  = 16'd3000;
  localparam logic [15:0] PULSE_MIN_RST = 16'd900;
  localparam logic [15:0] PULSE_MAX_RST = 16'd2100;
  localparam logic [31:0] TIMEOUT_RST   = 32'd100000;

  // Channel value after reset
  localparam logic [15:0] VALUE_RST     = 16'd1500;
  localparam logic [15:0] VALUE_RST_LOW = 16'd1000;

  // Sample ring
  localparam int         RING_DEPTH = 3;
  localparam logic [1:0] RING_LAST  = 2'(RING_DEPTH - 1);

  // Register indexes
  localparam logic [7:0] REG_SYNC_MIN  = 8'd0;
  localparam logic [7:0] REG_PULSE_MIN = 8'd1;
  localparam logic [7:0] REG_PULSE_MAX = 8'd2;
  localparam logic [7:0] REG_TIMEOUT   = 8'd3;

  // Item commands
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // Per-channel record held in the channel RAM
  typedef struct packed {
    logic [RING_DEPTH-1:0][15:0] samp;
    logic [1:0]                  pos;
    logic [15:0]                 value;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Configuration registers
  typedef struct packed {
    logic [15:0] sync_min;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
    logic [31:0] timeout;
  } cfg_t;

  // Item state carried from the accept stage to the update stage
  typedef struct packed {
    logic        is_read;
    logic        in_range;
    logic        update;
    logic        sync_seen;
    logic        connected;
    logic        rec_valid;
    logic [7:0]  slot;
    logic [15:0] gap;
  } stage_t;

  // Result item
  typedef struct packed {
    logic [15:0] value;
    logic [7:0]  slot;
    logic        updated;
    logic        sync_seen;
    logic        connected;
  } res_t;

  // Median of three
  function automatic logic [15:0] mid3(input logic [15:0] x, input logic [15:0] y,
                                       input logic [15:0] z);
    logic [15:0] m;
    if (x > y) begin
      if (y > z) m = y;
      else m = (x > z) ? z : x;
    end else begin
      if (x > z) m = x;
      else m = (y > z) ? z : y;
    end
    return m;
  endfunction

  // Channel value after reset: channels 2, 4 and 5 start low
  function automatic logic [15:0] rst_value(input logic [7:0] ch);
    logic [15:0] v;
    if (ch == 8'd2 || ch == 8'd4 || ch == 8'd5) v = VALUE_RST_LOW;
    else v = VALUE_RST;
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/ppm_item_if.sv =====
// Input item channel: edge event or read request.
`default_nettype none

interface ppm_item_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] time_us;
  logic [7:0]  chan_sel;

  modport source (output valid, cmd, time_us, chan_sel, input ready);
  modport sink   (input valid, cmd, time_us, chan_sel, output ready);
endinterface

`default_nettype wire

// ===== src/ppm_result_if.sv =====
// Result item channel.
`default_nettype none

interface ppm_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [7:0]  slot;
  logic        updated;
  logic        sync_seen;
  logic        connected;

  modport source (output valid, value, slot, updated, sync_seen, connected, input ready);
  modport sink   (input valid, value, slot, updated, sync_seen, connected, output ready);
endinterface

`default_nettype wire

// ===== src/ppm_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface ppm_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== src/ppm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ppm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ppm_cfg.sv =====
// Configuration registers of the PPM decoder.
`default_nettype none

module ppm_cfg (
  input  wire logic    clk,
  input  wire logic    rst,
  ppm_cfg_if.sink      cfg,
  output ppm_pkg::cfg_t regs
);

  assign cfg.ready = 1'b1;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_min  <= ppm_pkg::SYNC_MIN_RST;
      regs.pulse_min <= ppm_pkg::PULSE_MIN_RST;
      regs.pulse_max <= ppm_pkg::PULSE_MAX_RST;
      regs.timeout   <= ppm_pkg::TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        ppm_pkg::REG_SYNC_MIN:  regs.sync_min  <= cfg.data[15:0];
        ppm_pkg::REG_PULSE_MIN: regs.pulse_min <= cfg.data[15:0];
        ppm_pkg::REG_PULSE_MAX: regs.pulse_max <= cfg.data[15:0];
        ppm_pkg::REG_TIMEOUT:   regs.timeout   <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/ppm_upd.sv =====
// Channel record update: ring write, median of three and result build.
`default_nettype none

module ppm_upd (
  input  wire ppm_pkg::stage_t st,
  input  wire ppm_pkg::rec_t   rd_rec,
  input  wire logic            fwd_hit,
  input  wire ppm_pkg::rec_t   fwd_rec,
  output ppm_pkg::rec_t        new_rec,
  output ppm_pkg::res_t        res
);

  ppm_pkg::rec_t cur;
  logic [1:0]    pos;

  // Current record: forwarded write, stored entry or reset contents
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_rec;
    end else if (st.rec_valid) begin
      cur = rd_rec;
    end else begin
      cur       = '0;
      cur.value = ppm_pkg::rst_value(st.slot);
    end
  end

  // Ring write and new median
  always_comb begin
    pos     = (cur.pos > ppm_pkg::RING_LAST) ? 2'd0 : cur.pos;
    new_rec = cur;
    for (int k = 0; k < ppm_pkg::RING_DEPTH; k++) begin
      if (pos == 2'(k)) new_rec.samp[k] = st.gap;
    end
    new_rec.pos   = (pos == ppm_pkg::RING_LAST) ? 2'd0 : pos + 2'd1;
    new_rec.value = ppm_pkg::mid3(new_rec.samp[0], new_rec.samp[1], new_rec.samp[2]);
  end

  // Result item
  always_comb begin
    if (st.update) res.value = new_rec.value;
    else if (st.is_read && st.in_range) res.value = cur.value;
    else res.value = 16'd0;
    res.slot      = st.slot;
    res.updated   = st.update;
    res.sync_seen = st.sync_seen;
    res.connected = st.connected;
  end

endmodule

`default_nettype wire

// ===== src/ppm_decoder_median_filter_core.sv =====
// Top level of the PPM decoder with per-channel three-sample median filter.
`default_nettype none

// PPM decoder. Each item is a rising edge (cmd 0, timestamp in microseconds) or a
// read of one channel (cmd 1). It takes one item per clock cycle while the result
// channel is not stalled and returns a result for each, through the update stage
// register and the output register. Edge timing, the channel counter and the link
// flag are worked out at acceptance; the per-channel record (three samples, ring
// position and filtered value) sits in one RAM, read at acceptance and written
// back from the update stage, with a forwarding register covering a read of the
// entry that is being written in the same cycle. The RAM needs no clearing pass:
// a valid bit per channel, cleared by reset, makes an unwritten entry read as its
// reset contents. A waiting result blocks intake only if the update stage is full.
module ppm_decoder_median_filter_core #(
  parameter int CHANNELS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst,
  ppm_item_if.sink       items,
  ppm_result_if.source   results,
  ppm_cfg_if.sink        cfg
);

  localparam int AW = $clog2(CHANNELS);
  localparam int CW = $clog2(CHANNELS + 1);

  ppm_pkg::cfg_t   regs;
  ppm_pkg::stage_t st_next;
  ppm_pkg::stage_t st;
  ppm_pkg::rec_t   rd_rec;
  ppm_pkg::rec_t   new_rec;
  ppm_pkg::rec_t   fwd_rec;
  ppm_pkg::res_t   res_next;
  ppm_pkg::res_t   res;

  logic          st_valid;
  logic          out_valid;
  logic          fwd_hit;
  logic          advance;
  logic          in_fire;
  logic          is_edge;
  logic [31:0]   gap;
  logic          is_sync;
  logic          in_win;
  logic          can_fill;
  logic          timed_out;
  logic          in_range;
  logic          update_now;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  logic [CW-1:0]       next_channel;
  logic [31:0]         last_edge_time;
  logic [31:0]         last_sync_time;
  logic                link_up;
  logic [CHANNELS-1:0] vld;

  ppm_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  // Handshake: the update stage moves on whenever the output register is free
  assign advance     = !out_valid || results.ready;
  assign items.ready = !st_valid || advance;
  assign in_fire     = items.valid && items.ready;

  // Edge classification and link timeout
  assign is_edge    = (items.cmd == ppm_pkg::CMD_EDGE);
  assign gap        = items.time_us - last_edge_time;
  assign is_sync    = gap > {16'd0, regs.sync_min};
  assign in_win     = (gap >= {16'd0, regs.pulse_min}) && (gap <= {16'd0, regs.pulse_max});
  assign can_fill   = next_channel < CW'(CHANNELS);
  assign timed_out  = (items.time_us - last_sync_time) > regs.timeout;
  assign in_range   = items.chan_sel < 8'(CHANNELS);
  assign update_now = is_edge && !is_sync && in_win && can_fill;
  assign rd_addr    = is_edge ? next_channel[AW-1:0] : items.chan_sel[AW-1:0];

  // Item state for the update stage
  always_comb begin
    st_next.is_read   = !is_edge;
    st_next.in_range  = in_range;
    st_next.update    = update_now;
    st_next.sync_seen = is_edge && is_sync;
    st_next.rec_valid = vld[rd_addr];
    st_next.gap       = gap[15:0];
    if (is_edge) begin
      st_next.connected = is_sync ? 1'b1 : link_up;
      st_next.slot      = update_now ? 8'(next_channel) : 8'd0;
    end else begin
      st_next.connected = link_up && !timed_out;
      st_next.slot      = items.chan_sel;
    end
  end

  // Frame timing, channel counter and link flag
  always_ff @(posedge clk) begin
    if (rst) begin
      next_channel   <= '0;
      last_edge_time <= '0;
      last_sync_time <= '0;
      link_up        <= 1'b0;
    end else if (in_fire) begin
      if (is_edge) begin
        last_edge_time <= items.time_us;
        if (is_sync) begin
          next_channel   <= '0;
          link_up        <= 1'b1;
          last_sync_time <= items.time_us;
        end else if (update_now) begin
          next_channel <= next_channel + CW'(1);
        end
      end else if (timed_out) begin
        link_up <= 1'b0;
      end
    end
  end

  // Channel record RAM
  assign wr_en   = st_valid && advance && st.update;
  assign wr_addr = st.slot[AW-1:0];

  ppm_ram #(
    .WIDTH (ppm_pkg::REC_W),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (new_rec),
    .re    (in_fire),
    .raddr (rd_addr),
    .rdata (rd_rec)
  );

  // Entry valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  // Update stage register and write forwarding
  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid <= 1'b0;
    end else if (in_fire) begin
      st_valid <= 1'b1;
    end else if (advance) begin
      st_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      st      <= st_next;
      fwd_hit <= wr_en && (wr_addr == rd_addr);
      fwd_rec <= new_rec;
    end
  end

  ppm_upd u_upd (
    .st      (st),
    .rd_rec  (rd_rec),
    .fwd_hit (fwd_hit),
    .fwd_rec (fwd_rec),
    .new_rec (new_rec),
    .res     (res_next)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= st_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && st_valid) res <= res_next;
  end

  assign results.valid     = out_valid;
  assign results.value     = res.value;
  assign results.slot      = res.slot;
  assign results.updated   = res.updated;
  assign results.sync_seen = res.sync_seen;
  assign results.connected = res.connected;

endmodule

`default_nettype wire

// ===== tb/sv/ppm_decode_checker.sv =====
// Checker for the PPM decoder: tracks the decoder state and compares every result item.
module ppm_decode_checker
  import ppm_pkg::*;
#(
  parameter int CHANNELS = 8
) (
  input  logic  clk,
  input  logic  rst,
  ppm_item_if   items,
  ppm_result_if results,
  ppm_cfg_if    cfg,
  output int    mismatch_count,
  output int    decodes_in_flight
);

  // Mirror of the configuration registers
  logic [15:0] sync_min_r;
  logic [15:0] pulse_min_r;
  logic [15:0] pulse_max_r;
  logic [31:0] timeout_r;

  // Mirror of the decoder state
  logic [15:0] chan_val [CHANNELS];
  logic [15:0] ring [CHANNELS][RING_DEPTH];
  logic [1:0]  ring_pos [CHANNELS];
  int unsigned next_ch;
  logic [31:0] last_edge;
  logic [31:0] last_sync;
  logic        link;

  // Decoded items still owed by the block, oldest first
  res_t decoded_items [$];

  function automatic logic [15:0] median3(input logic [15:0] a, input logic [15:0] b,
                                          input logic [15:0] c);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c < lo) return lo;
    if (c > hi) return hi;
    return c;
  endfunction

  // Apply one item to the mirrored state and work out its result
  task automatic decode_ppm_item(input logic c, input logic [31:0] t, input logic [7:0] ch,
                                 output res_t r);
    logic [31:0] gap;
    int unsigned k;
    logic [1:0]  p;
    r = '0;
    if (c == CMD_READ) begin
      // link loss is only noticed on a read
      if (t - last_sync > timeout_r) link = 1'b0;
      if (ch < CHANNELS) r.value = chan_val[ch];
      r.slot = ch;
    end else begin
      gap = t - last_edge;
      last_edge = t;
      if (gap > {16'd0, sync_min_r}) begin
        next_ch = 0;
        link = 1'b1;
        last_sync = t;
        r.sync_seen = 1'b1;
      end else if (gap >= {16'd0, pulse_min_r} && gap <= {16'd0, pulse_max_r}) begin
        // counter stops once every channel has had its pulse this frame
        if (next_ch < CHANNELS) begin
          k = next_ch;
          p = ring_pos[k];
          if (p >= RING_DEPTH) p = 2'd0;
          ring[k][p] = gap[15:0];
          ring_pos[k] = (p == RING_LAST) ? 2'd0 : p + 2'd1;
          chan_val[k] = median3(ring[k][0], ring[k][1], ring[k][2]);
          r.value = chan_val[k];
          r.slot = k[7:0];
          r.updated = 1'b1;
          next_ch = k + 1;
        end
      end
    end
    r.connected = link;
  endtask

  // Watch the three channels
  always @(posedge clk) begin : watch
    res_t want;
    res_t got;
    if (rst) begin
      sync_min_r  = SYNC_MIN_RST;
      pulse_min_r = PULSE_MIN_RST;
      pulse_max_r = PULSE_MAX_RST;
      timeout_r   = TIMEOUT_RST;
      for (int i = 0; i < CHANNELS; i++) begin
        chan_val[i] = (i == 2 || i == 4 || i == 5) ? VALUE_RST_LOW : VALUE_RST;
        ring_pos[i] = 2'd0;
        for (int j = 0; j < RING_DEPTH; j++) ring[i][j] = 16'd0;
      end
      next_ch   = 0;
      last_edge = 32'd0;
      last_sync = 32'd0;
      link      = 1'b0;
      decoded_items.delete();
      mismatch_count = 0;
      decodes_in_flight <= 0;
    end else begin
      // register writes
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SYNC_MIN:  sync_min_r  = cfg.data[15:0];
          REG_PULSE_MIN: pulse_min_r = cfg.data[15:0];
          REG_PULSE_MAX: pulse_max_r = cfg.data[15:0];
          REG_TIMEOUT:   timeout_r   = cfg.data;
          default: ;
        endcase
      end
      // result items against the oldest owed one
      if (results.valid && results.ready) begin
        got.value     = results.value;
        got.slot      = results.slot;
        got.updated   = results.updated;
        got.sync_seen = results.sync_seen;
        got.connected = results.connected;
        if (decoded_items.size() == 0) begin
          $error("result item with none owed: value %0d slot %0d", got.value, got.slot);
          mismatch_count++;
        end else begin
          want = decoded_items.pop_front();
          if (got.value !== want.value) begin
            $error("value: expected %0d, actual %0d", want.value, got.value);
            mismatch_count++;
          end
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d, actual %0d", want.slot, got.slot);
            mismatch_count++;
          end
          if (got.updated !== want.updated) begin
            $error("updated: expected %0b, actual %0b", want.updated, got.updated);
            mismatch_count++;
          end
          if (got.sync_seen !== want.sync_seen) begin
            $error("sync_seen: expected %0b, actual %0b", want.sync_seen, got.sync_seen);
            mismatch_count++;
          end
          if (got.connected !== want.connected) begin
            $error("connected: expected %0b, actual %0b", want.connected, got.connected);
            mismatch_count++;
          end
        end
      end
      // input items
      if (items.valid && items.ready) begin
        decode_ppm_item(items.cmd, items.time_us, items.chan_sel, want);
        decoded_items.push_back(want);
      end
      decodes_in_flight <= decoded_items.size();
    end
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the PPM decoder testbench: clock, reset, stimulus and verdict.
module tb_top;
  import ppm_pkg::*;

  localparam int CHANNELS = 8;

  logic clk;
  logic rst;

  ppm_item_if   items_ch ();
  ppm_result_if res_ch ();
  ppm_cfg_if    cfg_ch ();

  int mismatch_count;
  int in_flight;

  ppm_decoder_median_filter_core #(.CHANNELS(CHANNELS)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  ppm_decode_checker #(.CHANNELS(CHANNELS)) i_checker (
    .clk               (clk),
    .rst               (rst),
    .items             (items_ch),
    .results           (res_ch),
    .cfg               (cfg_ch),
    .mismatch_count    (mismatch_count),
    .decodes_in_flight (in_flight)
  );

  // Stimulus state
  logic [31:0] now;
  logic [31:0] sync_at;
  logic [15:0] stim_sync;
  logic [15:0] stim_pmin;
  logic [15:0] stim_pmax;
  logic [31:0] stim_timeout;
  int unsigned sent;
  int unsigned idle_rate;
  bit          calm;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Run limit
  initial begin
    #3000000;
    $display("tb_top: errors");
    $finish;
  end

  // Result side back-pressure in bursts
  initial begin : sink_stall
    int unsigned stall_left;
    int unsigned run_left;
    stall_left = 0;
    run_left = 0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (calm) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (stall_left == 0 && run_left == 0) begin
          if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 16);
          else run_left = $urandom_range(1, 40);
        end
        if (stall_left > 0) begin
          res_ch.ready <= 1'b0;
          stall_left--;
        end else begin
          res_ch.ready <= 1'b1;
          run_left--;
        end
      end
    end
  end

  // Offer one item, with an occasional idle burst before it
  task automatic send_item(input logic c, input logic [31:0] t, input logic [7:0] ch);
    if (!calm && idle_rate != 0 && $urandom_range(1, idle_rate) == 1) begin
      items_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    items_ch.valid    <= 1'b1;
    items_ch.cmd      <= c;
    items_ch.time_us  <= t;
    items_ch.chan_sel <= ch;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic edge_after(input logic [31:0] gap);
    now = now + gap;
    send_item(CMD_EDGE, now, 8'($urandom_range(0, 255)));
  endtask

  // Stop sending and wait until every owed result item has come back
  task automatic drain();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic write_config(input logic [15:0] s, input logic [15:0] lo,
                              input logic [15:0] hi, input logic [31:0] to);
    put_reg(REG_SYNC_MIN, {16'd0, s});
    put_reg(REG_PULSE_MIN, {16'd0, lo});
    put_reg(REG_PULSE_MAX, {16'd0, hi});
    put_reg(REG_TIMEOUT, to);
    cfg_ch.valid <= 1'b0;
    stim_sync    = s;
    stim_pmin    = lo;
    stim_pmax    = hi;
    stim_timeout = to;
  endtask

  function automatic logic [31:0] sync_gap();
    return {16'd0, stim_sync} + 32'd1 + $urandom_range(0, 15000);
  endfunction

  function automatic logic [31:0] pulse_gap();
    case ($urandom_range(0, 7))
      0: return {16'd0, stim_pmin};
      1: return {16'd0, stim_pmax};
      default: begin
        if (stim_pmin <= stim_pmax) return $urandom_range(stim_pmin, stim_pmax);
        return $urandom_range(0, 4000);
      end
    endcase
  endfunction

  // Read of a channel at a time near now, near the link timeout, or anywhere
  task automatic random_read();
    logic [7:0]  ch;
    logic [31:0] t;
    ch = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
                                       8'($urandom_range(0, CHANNELS + 1));
    case ($urandom_range(0, 5))
      0, 1, 2: t = now + $urandom_range(0, 3000);
      3:       t = sync_at + stim_timeout;
      4:       t = sync_at + stim_timeout + 32'd1;
      default: t = $urandom;
    endcase
    send_item(CMD_READ, t, ch);
  endtask

  // Sync gap, a run of pulses around the channel count, reads mixed in
  task automatic frame();
    int n;
    edge_after(sync_gap());
    sync_at = now;
    n = $urandom_range(CHANNELS - 2, CHANNELS + 2);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 5) == 0) random_read();
      edge_after(pulse_gap());
    end
  endtask

  // Edges with arbitrary gaps, including jumps across the timestamp wrap
  task automatic noise();
    case ($urandom_range(0, 3))
      0: begin
        now = $urandom;
        send_item(CMD_EDGE, now, 8'($urandom_range(0, 255)));
      end
      1: begin
        now = 32'hFFFF_FFFF - $urandom_range(0, 20000);
        send_item(CMD_EDGE, now, 8'($urandom_range(0, 255)));
      end
      default: edge_after($urandom_range(0, 70000));
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase_end;
    int unsigned pick;
    bit          paused;
    items_ch.valid    = 1'b0;
    items_ch.cmd      = CMD_EDGE;
    items_ch.time_us  = 32'd0;
    items_ch.chan_sel = 8'd0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_SYNC_MIN;
    cfg_ch.data       = 32'd0;
    now          = 32'd0;
    sync_at      = 32'd0;
    stim_sync    = SYNC_MIN_RST;
    stim_pmin    = PULSE_MIN_RST;
    stim_pmax    = PULSE_MAX_RST;
    stim_timeout = TIMEOUT_RST;
    sent         = 0;
    idle_rate    = 6;
    calm         = 1'b0;
    paused       = 1'b0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, out-of-range reads, window edges, full counter, timeout
    send_item(CMD_READ, 32'd0, 8'd0);
    send_item(CMD_READ, 32'd0, 8'd2);
    send_item(CMD_READ, 32'd0, 8'd8);
    send_item(CMD_READ, 32'hFFFF_FFFF, 8'd255);
    edge_after(32'd3001);
    sync_at = now;
    edge_after(32'd900);
    edge_after(32'd2100);
    edge_after(32'd899);
    edge_after(32'd2101);
    edge_after(32'd3000);
    for (int i = 2; i < CHANNELS; i++) edge_after($urandom_range(900, 2100));
    edge_after(32'd1500);
    send_item(CMD_READ, now, 8'd1);
    send_item(CMD_READ, sync_at + 32'd100000, 8'd5);
    send_item(CMD_READ, sync_at + 32'd100001, 8'd7);
    edge_after(32'd1500);

    // Random phases, each under its own register setting
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: idle_rate = 8;
        1: begin
          write_config(16'hFFFF, 16'h0000, 16'hFFFF, 32'd0);
          idle_rate = 3;
        end
        2: begin
          write_config(16'h0000, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
          idle_rate = 0;
        end
        3: begin
          write_config(16'd4000, 16'd1000, 16'd2000, 32'd50000);
          idle_rate = 8;
        end
        4: begin
          write_config(16'($urandom_range(2500, 20000)), 16'($urandom_range(0, 1500)),
                       16'($urandom_range(1500, 3000)), $urandom_range(20000, 300000));
          idle_rate = 3;
        end
        default: begin
          write_config(SYNC_MIN_RST, PULSE_MIN_RST, PULSE_MAX_RST, TIMEOUT_RST);
          calm = 1'b1;
        end
      endcase
      phase_end = sent + 120;
      while (sent < phase_end) begin
        // one pause until the block has emptied, mid-stream
        if (phase == 1 && !paused && sent + 60 >= phase_end) begin
          drain();
          paused = 1'b1;
        end
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          frame();
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 4)) random_read();
        end else begin
          repeat ($urandom_range(1, 3)) noise();
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/ppm_pkg.sv
src/ppm_item_if.sv
src/ppm_result_if.sv
src/ppm_cfg_if.sv
src/ppm_ram.sv
src/ppm_cfg.sv
src/ppm_upd.sv
src/ppm_decoder_median_filter_core.sv
tb/sv/ppm_decode_checker.sv
tb/sv/tb_top.sv
